// ===== rtl/core/shabc_pkg.sv =====
// shared types and constants of the sha-256 block compression core
`timescale 1ns / 1ps

package shabc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned WinLen  = 16;
  localparam int unsigned HashLen = 8;
  localparam int unsigned RoundW  = $clog2(Rounds);
  localparam int unsigned PosW    = $clog2(WinLen);
  localparam int unsigned HashIdxW = $clog2(HashLen);

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             start_message;
    logic             end_message;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic             last_digest_word;
  } out_item_t;

  typedef struct packed {
    logic                load_word;
    logic                reload_iv;
    logic                init_work;
    logic                round_en;
    logic                add_en;
    logic [RoundW-1:0]   round_idx;
    logic [HashIdxW-1:0] out_idx;
  } cmd_t;

  localparam logic [WordW-1:0] InitHash [HashLen] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/core/shabc_ctrl.sv =====
// controller state machine: word counting, round sequencing, digest output
`timescale 1ns / 1ps

module shabc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 start_i,
  input  logic                 end_i,
  input  logic                 out_stall_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output shabc_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd   = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  localparam logic [shabc_pkg::PosW-1:0] LastPos =
    shabc_pkg::PosW'(shabc_pkg::WinLen - 1);
  localparam logic [shabc_pkg::RoundW-1:0] LastRound =
    shabc_pkg::RoundW'(shabc_pkg::Rounds - 1);
  localparam logic [shabc_pkg::HashIdxW-1:0] LastIdx =
    shabc_pkg::HashIdxW'(shabc_pkg::HashLen - 1);

  logic [1:0]                      state_q, state_d;
  logic [shabc_pkg::PosW-1:0]      pos_q, pos_d, pos_eff;
  logic [shabc_pkg::RoundW-1:0]    rnd_q, rnd_d;
  logic [shabc_pkg::HashIdxW-1:0]  oidx_q, oidx_d;
  logic                            fin_q, fin_d;
  logic                            in_acc;

  assign in_stall_o  = (state_q != StLoad);
  assign out_valid_o = (state_q == StOut);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pos_eff     = start_i ? '0 : pos_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = oidx_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          cmd_o.load_word = 1'b1;
          cmd_o.reload_iv = start_i;
          pos_d = pos_eff + 1'b1;
          if (pos_eff == LastPos) begin
            cmd_o.init_work = 1'b1;
            fin_d   = end_i;
            state_d = StRound;
          end
        end
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == LastRound) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        cmd_o.add_en = 1'b1;
        state_d = fin_q ? StOut : StLoad;
      end
      StOut: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 1'b1;
          if (oidx_q == LastIdx) begin
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      pos_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      fin_q   <= fin_d;
    end
  end

  a_round_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == LastRound) |=> (state_q == StAdd))
    else $error("rounds did not end in the add step");

  a_load_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> (rnd_q == '0 && oidx_q == '0))
    else $error("round or output counter not idle while loading");

  a_block_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_eff == LastPos) |=> (state_q == StRound && rnd_q == '0))
    else $error("full block did not start the rounds");

  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && oidx_q == LastIdx) |=> (state_q == StLoad))
    else $error("digest output did not return to loading");

endmodule

// ===== rtl/core/shabc_datapath.sv =====
// datapath: schedule window, working variables, chaining words, round logic
`timescale 1ns / 1ps

module shabc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  shabc_pkg::cmd_t      cmd_i,
  input  logic [31:0]          word_i,
  output shabc_pkg::out_item_t out_data_o
);

  localparam int unsigned WL = shabc_pkg::WinLen;
  localparam int unsigned HL = shabc_pkg::HashLen;
  localparam logic [shabc_pkg::HashIdxW-1:0] LastIdx =
    shabc_pkg::HashIdxW'(HL - 1);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] win_q   [WL];
  logic [31:0] work_q  [HL];
  logic [31:0] chain_q [HL];

  logic [31:0] sm0, sm1, w_next;
  logic [31:0] big0, big1, ch, maj, t1, t2;

  // next schedule word from the window holding w[t] .. w[t+15]
  always_comb begin
    sm0 = ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3);
    sm1 = ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10);
    w_next = win_q[0] + sm0 + win_q[9] + sm1;
  end

  always_comb begin
    big1 = ror(work_q[4], 6) ^ ror(work_q[4], 11) ^ ror(work_q[4], 25);
    ch   = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    t1   = work_q[7] + big1 + ch + shabc_pkg::RoundK[cmd_i.round_idx] + win_q[0];
    big0 = ror(work_q[0], 2) ^ ror(work_q[0], 13) ^ ror(work_q[0], 22);
    maj  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word || cmd_i.round_en) begin
      for (int i = 0; i < WL - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WL-1] <= cmd_i.load_word ? word_i : w_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_work) begin
      for (int i = 0; i < HL; i++) begin
        work_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round_en) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HL; i++) begin
        chain_q[i] <= shabc_pkg::InitHash[i];
      end
    end else if (cmd_i.reload_iv) begin
      for (int i = 0; i < HL; i++) begin
        chain_q[i] <= shabc_pkg::InitHash[i];
      end
    end else if (cmd_i.add_en) begin
      for (int i = 0; i < HL; i++) begin
        chain_q[i] <= chain_q[i] + work_q[i];
      end
    end
  end

  assign out_data_o.digest_word      = chain_q[cmd_i.out_idx];
  assign out_data_o.last_digest_word = (cmd_i.out_idx == LastIdx);

endmodule

// ===== rtl/core/sha256_block_compress.sv =====
// top level of the sha-256 block compression core
`timescale 1ns / 1ps

// Input channel: one 32-bit big-endian word of an already padded message per
// transaction, sixteen per 512-bit block. start_message on the first word
// reloads the initial hash values; end_message on the sixteenth word of the
// final block requests the digest.
// Output channel: eight transactions carrying the digest words, first word
// first, last_digest_word set on the eighth.
// Timing: the sixteenth word of a block starts the 64 rounds (one round per
// cycle in the round unit) and then the chaining-word add. The digest
// follows the add, one word per cycle unless stalled.
// in_stall_o is high from the sixteenth word until the block is compressed
// and, for the final block, until the last digest word is taken; a stall on
// the output holds the current digest word and the block waits.
// Reset: the chaining words hold the initial hash values and the word count
// is zero; the block accepts words right after reset is released.

module sha256_block_compress (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  shabc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output shabc_pkg::out_item_t out_data_o
);

  shabc_pkg::cmd_t cmd;

  shabc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .start_i     (in_data_i.start_message),
    .end_i       (in_data_i.end_message),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  shabc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .word_i     (in_data_i.message_word),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/sha256_block_compress_checker.sv =====
// checker for the sha-256 block compression core: predicts digests and compares transactions
`timescale 1ns / 1ps

module sha256_block_compress_checker
  import shabc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [WordW-1:0] chain_r [HashLen];
  logic [WordW-1:0] sched_r [WinLen];
  logic [PosW-1:0]  pos_r;
  out_item_t        digest_q [$];
  int               errors;

  function automatic logic [WordW-1:0] rotr(logic [WordW-1:0] x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic void reload_iv();
    for (int k = 0; k < HashLen; k++) chain_r[k] = InitHash[k];
  endfunction

  function automatic void compress_block();
    logic [WordW-1:0] v [HashLen];
    logic [WordW-1:0] w, w15, w2, sig0, sig1, t1, t2;
    for (int k = 0; k < HashLen; k++) v[k] = chain_r[k];
    for (int t = 0; t < Rounds; t++) begin
      if (t < WinLen) begin
        w = sched_r[t];
      end else begin
        w15  = sched_r[(t - 15) & 15];
        w2   = sched_r[(t - 2) & 15];
        sig0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        sig1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        w = sched_r[t & 15] + sig0 + sched_r[(t - 7) & 15] + sig1;
        sched_r[t & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int k = 0; k < HashLen; k++) chain_r[k] = chain_r[k] + v[k];
  endfunction

  function automatic void absorb_word(in_item_t item);
    out_item_t       digest;
    logic [PosW-1:0] slot;
    if (item.start_message) begin
      reload_iv();
      pos_r = '0;
    end
    slot = pos_r;
    sched_r[slot] = item.message_word;
    pos_r = slot + 1'b1;
    if (slot == WinLen - 1) begin
      compress_block();
      if (item.end_message) begin
        for (int k = 0; k < HashLen; k++) begin
          digest.digest_word      = chain_r[k];
          digest.last_digest_word = (k == HashLen - 1);
          digest_q.push_back(digest);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      reload_iv();
      pos_r = '0;
      digest_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("digest transaction with nothing expected: digest_word %h last_digest_word %b",
                 out_data_i.digest_word, out_data_i.last_digest_word);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (out_data_i.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, out_data_i.digest_word);
            errors++;
          end
          if (out_data_i.last_digest_word !== want.last_digest_word) begin
            $error("last_digest_word: expected %b, got %b",
                   want.last_digest_word, out_data_i.last_digest_word);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb_word(in_data_i);
      fail_count_o <= errors;
      pending_o    <= digest_q.size();
    end
  end

endmodule

// ===== tb/sha256_block_compress_tb.sv =====
// testbench top for the sha-256 block compression core: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module sha256_block_compress_tb;
  import shabc_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int WordTarget = 370;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  int        words_sent = 0;
  bit        no_gaps = 1'b0;

  sha256_block_compress u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  sha256_block_compress_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input logic s, input logic e);
    in_item_t item;
    int       gap;
    item.message_word  = w;
    item.start_message = s;
    item.end_message   = e;
    gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(input int nblocks, input bit with_start, input bit stray_ends);
    logic s, e;
    for (int b = 0; b < nblocks; b++) begin
      for (int i = 0; i < WinLen; i++) begin
        s = with_start && b == 0 && i == 0;
        e = (b == nblocks - 1 && i == WinLen - 1)
          || (stray_ends && i != WinLen - 1 && $urandom_range(0, 3) == 0);
        send_word(pick_word(), s, e);
      end
    end
  endtask

  task automatic wait_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // output side stall pattern, with quiet stretches
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    rst_n    = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start and end on the same word, then end flags in mid-block
    send_word('1, 1'b1, 1'b1);
    send_word('0, 1'b0, 1'b1);
    send_word(32'h8000_0000, 1'b0, 1'b1);
    // start mid-block discards the partial block; extreme words
    for (int i = 0; i < WinLen; i++) begin
      case (i % 4)
        0: send_word('0, i == 0, 1'b0);
        1: send_word('1, 1'b0, 1'b0);
        2: send_word(32'h0000_0001, 1'b0, 1'b0);
        default: send_word(32'h8000_0000, 1'b0, i == WinLen - 1);
      endcase
    end
    wait_digests();

    while (words_sent < WordTarget) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_message((r < 50) ? 1 : $urandom_range(2, 3), 1'b1, 1'b0);
      end else if (r < 70) begin
        send_message(1, 1'b0, 1'b0);
      end else if (r < 78) begin
        send_message(1, 1'b1, 1'b1);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 15))
          send_word(pick_word(), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
      end else begin
        wait_digests();
      end
    end

    wait_digests();
    repeat (100) @(posedge clk);
    if (pending != 0) $error("%0d digest words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/shabc_pkg.sv
rtl/core/shabc_ctrl.sv
rtl/core/shabc_datapath.sv
rtl/core/sha256_block_compress.sv
tb/sha256_block_compress_checker.sv
tb/sha256_block_compress_tb.sv
